>>> design/cnms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnms_pkg
// Shared types and constants of the cross-neighbour mean smoother.
// ----------------------------------------------------------------------------
package cnms_pkg;

   // fixed field widths
   localparam int SAMPLE_W    = 16;
   localparam int ROW_OUT_W   = 10;
   localparam int COL_OUT_W   = 10;
   localparam int CFG_W       = 11;
   localparam int CSR_INDEX_W = 1;
   localparam int COUNT_W     = 3;

   localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

   // item opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_DRAIN  = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ROW_COUNT    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_COLUMN_COUNT = 1'b1;

   typedef struct packed {
      logic                op;
      logic [SAMPLE_W-1:0] sample;
   } cnms_req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0]  smoothed;
      logic [ROW_OUT_W-1:0] out_row;
      logic [COL_OUT_W-1:0] out_column;
      logic                 frame_end;
   } cnms_rsp_type;

   // position and flag of a result in flight
   typedef struct packed {
      logic [ROW_OUT_W-1:0] row;
      logic [COL_OUT_W-1:0] col;
      logic                 frame_end;
   } cnms_meta_type;

   // which store taps join the sum
   typedef struct packed {
      logic               swap;
      logic               use_left;
      logic               use_right;
      logic               use_below;
      logic [COUNT_W-1:0] count;
   } cnms_taps_type;

endpackage

>>> design/cross_neighbour_mean_smoother_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cross_neighbour_mean_smoother_unit
// Five-point cross mean over a raster-order frame, two rows of line store.
// ----------------------------------------------------------------------------
// Pipeline: store read registered at the accepting edge, then sum, upper
//   quotient digits, lower digits + output register.
// Throughput: one item per cycle while rsp_ready does not hold the pipeline;
//   each item does all of its store reads and its write at acceptance, over
//   two dual-read banks (even / odd columns).
// Reset: synchronous; clears positions, frame flag and pipeline valids, sets
//   both counts to 1024. The line store is not cleared.
// ----------------------------------------------------------------------------
module cross_neighbour_mean_smoother_unit #(
   parameter int MAX_COLUMNS = 1024,
   parameter int MAX_ROWS    = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  cnms_pkg::cnms_req_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output cnms_pkg::cnms_rsp_type               rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cnms_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cnms_pkg::CFG_W-1:0]           csr_data
);
   import cnms_pkg::*;

   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W  = $clog2(MAX_COLUMNS);
   localparam int RCNT_W = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
   localparam int CCNT_W = ($clog2(MAX_COLUMNS + 1) > CFG_W) ?
                           $clog2(MAX_COLUMNS + 1) : CFG_W;
   // each bank holds every other column of both rows
   localparam int HALF       = (MAX_COLUMNS + 1) / 2;
   localparam int IDX_W      = (HALF > 1) ? $clog2(HALF) : 1;
   localparam int ADDR_W     = IDX_W + 1;
   localparam int BANK_DEPTH = 2 ** ADDR_W;
   localparam int SUM_W      = SAMPLE_BITS + 3;

   // configuration
   logic [CFG_W-1:0]  row_count_ff, row_count_in;
   logic [CFG_W-1:0]  column_count_ff, column_count_in;
   logic [RCNT_W-1:0] row_cfg_ext, rows_eff;
   logic [CCNT_W-1:0] col_cfg_ext, cols_eff;

   // frame position
   logic [ROW_W-1:0]  in_row_ff, in_row_in;
   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [COL_W-1:0]  drain_col_ff, drain_col_in;
   logic              frame_full_ff, frame_full_in;

   logic [ROW_W-1:0]  cur_row, drain_row;
   logic [COL_W-1:0]  cur_col, drain_col, sel_col;
   logic              is_sample, accept, produce;
   logic              has_left, has_right, col_last, row_last;
   logic [31:0]       sample_wide;
   logic [SAMPLE_BITS-1:0] sample_v;

   // store addressing
   logic [COL_W:0]    sel_col_ext, left_col_ext, right_col_ext;
   logic [IDX_W-1:0]  idx_c, idx_l, idx_r;
   logic              half_a, half_b, bank_sel;
   logic [ADDR_W-1:0] near_a, near_b, far_a, far_b, wr_addr;
   logic [ADDR_W-1:0] bank0_addr_a, bank0_addr_b, bank1_addr_a, bank1_addr_b;
   logic [SAMPLE_BITS-1:0] bank0_q_a, bank0_q_b, bank1_q_a, bank1_q_b;
   logic              store_wr, bank0_wr, bank1_wr;

   cnms_taps_type     taps_new;
   cnms_meta_type     meta_new;

   // pipeline
   logic              s1_ready, s2_ready, div_in_ready;
   logic              v1_ff, v1_in;
   cnms_taps_type     taps1_ff, taps1_in;
   logic [SAMPLE_BITS-1:0] sample1_ff, sample1_in;
   cnms_meta_type     meta1_ff, meta1_in;
   logic [SAMPLE_BITS-1:0] tap_center, tap_below, tap_left, tap_right;
   logic [SUM_W-1:0]  sum_new;
   logic              v2_ff, v2_in;
   logic [SUM_W-1:0]  sum2_ff, sum2_in;
   logic [COUNT_W-1:0] count2_ff, count2_in;
   cnms_meta_type     meta2_ff, meta2_in;

   // ---------------- configuration port ----------------
   assign csr_ready = 1'b1;

   always_comb begin
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_ROW_COUNT:    row_count_in    = csr_data;
            REG_COLUMN_COUNT: column_count_in = csr_data;
            default: ;
         endcase
      end
   end

   // zero acts as one, above the maximum clamps
   assign row_cfg_ext = RCNT_W'(row_count_ff);
   assign col_cfg_ext = CCNT_W'(column_count_ff);
   assign rows_eff = (row_count_ff == '0) ? RCNT_W'(1) :
                     (row_cfg_ext > RCNT_W'(MAX_ROWS)) ? RCNT_W'(MAX_ROWS) : row_cfg_ext;
   assign cols_eff = (column_count_ff == '0) ? CCNT_W'(1) :
                     (col_cfg_ext > CCNT_W'(MAX_COLUMNS)) ? CCNT_W'(MAX_COLUMNS) :
                     col_cfg_ext;

   // ---------------- position decode ----------------
   // positions beyond a shrunk frame saturate to its last row / column
   assign cur_row   = (RCNT_W'(in_row_ff) < rows_eff) ? in_row_ff :
                      ROW_W'(rows_eff - RCNT_W'(1));
   assign cur_col   = (CCNT_W'(in_col_ff) < cols_eff) ? in_col_ff :
                      COL_W'(cols_eff - CCNT_W'(1));
   assign drain_row = ROW_W'(rows_eff - RCNT_W'(1));
   assign drain_col = (CCNT_W'(drain_col_ff) < cols_eff) ? drain_col_ff :
                      COL_W'(cols_eff - CCNT_W'(1));

   assign is_sample = (req_data.op == OP_SAMPLE);
   assign sel_col   = is_sample ? cur_col : drain_col;
   assign has_left  = (sel_col != '0);
   assign has_right = (CCNT_W'(sel_col) + CCNT_W'(1)) < cols_eff;
   assign col_last  = !has_right;
   assign row_last  = (RCNT_W'(cur_row) + RCNT_W'(1)) >= rows_eff;

   assign sample_wide = {16'b0, req_data.sample};
   assign sample_v    = sample_wide[SAMPLE_BITS-1:0];

   assign req_ready = s1_ready;
   assign accept    = req_valid && req_ready;
   // a sample gives the result of the row above; a drain releases the last row
   assign produce   = is_sample ? (!frame_full_ff && (cur_row != '0)) : frame_full_ff;

   always_comb begin
      taps_new.swap      = sel_col[0];
      taps_new.use_left  = has_left;
      taps_new.use_right = has_right;
      meta_new.col       = COL_OUT_W'(sel_col);
      if (is_sample) begin
         taps_new.use_below = RCNT_W'(cur_row) >= RCNT_W'(2);
         taps_new.count     = COUNT_W'(2) + COUNT_W'(has_left) + COUNT_W'(has_right)
                              + COUNT_W'(taps_new.use_below);
         meta_new.row       = ROW_OUT_W'(cur_row - ROW_W'(1));
         meta_new.frame_end = 1'b0;
         half_a             = ~cur_row[0];
         half_b             = cur_row[0];
      end else begin
         taps_new.use_below = rows_eff > RCNT_W'(1);
         taps_new.count     = COUNT_W'(1) + COUNT_W'(has_left) + COUNT_W'(has_right)
                              + COUNT_W'(taps_new.use_below);
         meta_new.row       = ROW_OUT_W'(drain_row);
         meta_new.frame_end = col_last;
         half_a             = drain_row[0];
         half_b             = ~drain_row[0];
      end
   end

   // ---------------- position update ----------------
   always_comb begin
      in_row_in     = in_row_ff;
      in_col_in     = in_col_ff;
      drain_col_in  = drain_col_ff;
      frame_full_in = frame_full_ff;
      if (accept) begin
         if (is_sample && !frame_full_ff) begin
            if (col_last) begin
               in_col_in = '0;
               if (row_last) begin
                  in_row_in     = cur_row;
                  frame_full_in = 1'b1;
                  drain_col_in  = '0;
               end else begin
                  in_row_in = cur_row + ROW_W'(1);
               end
            end else begin
               in_row_in = cur_row;
               in_col_in = cur_col + COL_W'(1);
            end
         end else if (!is_sample && frame_full_ff) begin
            if (col_last) begin
               // frame done, start over
               frame_full_in = 1'b0;
               in_row_in     = '0;
               in_col_in     = '0;
               drain_col_in  = '0;
            end else begin
               drain_col_in = drain_col + COL_W'(1);
            end
         end
      end
   end

   // ---------------- store access ----------------
   // Center column lives in bank sel_col[0] (row A tap and row B tap there);
   // left and right neighbors share the other bank.
   assign sel_col_ext   = {1'b0, sel_col};
   assign left_col_ext  = sel_col_ext - (COL_W+1)'(1);
   assign right_col_ext = sel_col_ext + (COL_W+1)'(1);
   assign idx_c = IDX_W'(sel_col_ext >> 1);
   assign idx_l = IDX_W'(left_col_ext >> 1);
   assign idx_r = IDX_W'(right_col_ext >> 1);

   assign bank_sel = sel_col[0];
   assign near_a   = {half_a, idx_c};
   assign near_b   = {half_b, idx_c};
   assign far_a    = {half_a, idx_l};
   assign far_b    = {half_a, idx_r};

   assign bank0_addr_a = bank_sel ? far_a : near_a;
   assign bank0_addr_b = bank_sel ? far_b : near_b;
   assign bank1_addr_a = bank_sel ? near_a : far_a;
   assign bank1_addr_b = bank_sel ? near_b : far_b;

   // write lands on the same edge as the reads; the RAM returns old data
   assign store_wr = accept && is_sample && !frame_full_ff;
   assign bank0_wr = store_wr && !bank_sel;
   assign bank1_wr = store_wr && bank_sel;
   assign wr_addr  = {cur_row[0], idx_c};

   cnms_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (BANK_DEPTH)
   ) u_bank0 (
      .clock     (clock),
      .wr_en     (bank0_wr),
      .wr_addr   (wr_addr),
      .wr_data   (sample_v),
      .rd_en     (s1_ready),
      .rd_addr_a (bank0_addr_a),
      .rd_addr_b (bank0_addr_b),
      .rd_data_a (bank0_q_a),
      .rd_data_b (bank0_q_b)
   );

   cnms_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (BANK_DEPTH)
   ) u_bank1 (
      .clock     (clock),
      .wr_en     (bank1_wr),
      .wr_addr   (wr_addr),
      .wr_data   (sample_v),
      .rd_en     (s1_ready),
      .rd_addr_a (bank1_addr_a),
      .rd_addr_b (bank1_addr_b),
      .rd_data_a (bank1_q_a),
      .rd_data_b (bank1_q_b)
   );

   // ---------------- stage 1: store read ----------------
   assign s1_ready   = !v1_ff || s2_ready;
   assign v1_in      = s1_ready ? (accept && produce) : v1_ff;
   assign taps1_in   = s1_ready ? taps_new : taps1_ff;
   assign sample1_in = s1_ready ? (is_sample ? sample_v : '0) : sample1_ff;
   assign meta1_in   = s1_ready ? meta_new : meta1_ff;

   // ---------------- stage 2: sum ----------------
   assign tap_center = taps1_ff.swap ? bank1_q_a : bank0_q_a;
   assign tap_below  = taps1_ff.swap ? bank1_q_b : bank0_q_b;
   assign tap_left   = taps1_ff.swap ? bank0_q_a : bank1_q_a;
   assign tap_right  = taps1_ff.swap ? bank0_q_b : bank1_q_b;

   assign sum_new = SUM_W'(sample1_ff) + SUM_W'(tap_center)
                  + (taps1_ff.use_left  ? SUM_W'(tap_left)  : SUM_W'(0))
                  + (taps1_ff.use_right ? SUM_W'(tap_right) : SUM_W'(0))
                  + (taps1_ff.use_below ? SUM_W'(tap_below) : SUM_W'(0));

   assign s2_ready  = !v2_ff || div_in_ready;
   assign v2_in     = s2_ready ? v1_ff : v2_ff;
   assign sum2_in   = s2_ready ? sum_new : sum2_ff;
   assign count2_in = s2_ready ? taps1_ff.count : count2_ff;
   assign meta2_in  = s2_ready ? meta1_ff : meta2_ff;

   // ---------------- stages 3-4: divide and output ----------------
   cnms_div #(
      .SUM_W (SUM_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_ready  (div_in_ready),
      .in_sum    (sum2_ff),
      .in_count  (count2_ff),
      .in_meta   (meta2_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= CFG_RESET;
         column_count_ff <= CFG_RESET;
         in_row_ff       <= '0;
         in_col_ff       <= '0;
         drain_col_ff    <= '0;
         frame_full_ff   <= 1'b0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
      end else begin
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         in_row_ff       <= in_row_in;
         in_col_ff       <= in_col_in;
         drain_col_ff    <= drain_col_in;
         frame_full_ff   <= frame_full_in;
         v1_ff           <= v1_in;
         v2_ff           <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      taps1_ff   <= taps1_in;
      sample1_ff <= sample1_in;
      meta1_ff   <= meta1_in;
      sum2_ff    <= sum2_in;
      count2_ff  <= count2_in;
      meta2_ff   <= meta2_in;
   end

endmodule

>>> design/cnms_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnms_ram
// Generic RAM: one write port, two read ports, registered read with enable.
// ----------------------------------------------------------------------------
module cnms_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff, rd_data_a_in;
   logic [WIDTH-1:0] rd_data_b_ff, rd_data_b_in;

   // read-first: a read at the written address returns the old word
   assign rd_data_a_in = rd_en ? mem_ff[rd_addr_a] : rd_data_a_ff;
   assign rd_data_b_in = rd_en ? mem_ff[rd_addr_b] : rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= rd_data_a_in;
      rd_data_b_ff <= rd_data_b_in;
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

>>> design/cnms_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnms_div
// Two-stage divider of a sum by a count of 1 to 5, one hex digit per step.
// ----------------------------------------------------------------------------
module cnms_div #(
   parameter int SUM_W = 19
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [SUM_W-1:0]                in_sum,
   input  logic [cnms_pkg::COUNT_W-1:0]    in_count,
   input  cnms_pkg::cnms_meta_type         in_meta,
   output logic                            out_valid,
   input  logic                            out_ready,
   output cnms_pkg::cnms_rsp_type          out_data
);
   import cnms_pkg::*;

   localparam int ND    = (SUM_W + 3) / 4;
   localparam int NH    = (ND + 1) / 2;
   localparam int NL    = ND - NH;
   localparam int PAD_W = 4 * ND;

   // {quotient digit, remainder}; val is below 16 * d
   function automatic logic [6:0] div_digit(input logic [6:0] val,
                                            input logic [COUNT_W-1:0] d);
      logic [3:0] q;
      logic [6:0] prod;
      logic [6:0] rem_full;
      q = '0;
      for (int k = 1; k < 16; k++) begin
         prod = 7'(k) * 7'(d);
         if (prod <= val) begin
            q = 4'(k);
         end
      end
      rem_full = val - 7'(q) * 7'(d);
      return {q, rem_full[2:0]};
   endfunction

   logic [PAD_W-1:0]   sum_pad;
   logic [4*NH-1:0]    q_hi;
   logic [2:0]         rem_hi;
   logic [4*NL-1:0]    q_lo;
   logic [2:0]         rem_lo;
   logic [PAD_W-1:0]   quot;
   logic               d1_ready, d2_ready;
   cnms_rsp_type       rsp_new;

   logic               d1_valid_ff, d1_valid_in;
   logic [4*NH-1:0]    d1_qhi_ff, d1_qhi_in;
   logic [2:0]         d1_rem_ff, d1_rem_in;
   logic [4*NL-1:0]    d1_low_ff, d1_low_in;
   logic [COUNT_W-1:0] d1_count_ff, d1_count_in;
   cnms_meta_type      d1_meta_ff, d1_meta_in;
   logic               d2_valid_ff, d2_valid_in;
   cnms_rsp_type       out_data_ff, out_data_in;

   assign d2_ready = !d2_valid_ff || out_ready;
   assign d1_ready = !d1_valid_ff || d2_ready;
   assign in_ready = d1_ready;

   // upper digits
   always_comb begin
      logic [6:0] step;
      sum_pad = PAD_W'(in_sum);
      rem_hi  = '0;
      q_hi    = '0;
      for (int i = 0; i < NH; i++) begin
         step = div_digit({rem_hi, sum_pad[PAD_W-1-4*i -: 4]}, in_count);
         q_hi[4*(NH-1-i) +: 4] = step[6:3];
         rem_hi = step[2:0];
      end
   end

   // lower digits
   always_comb begin
      logic [6:0] step;
      rem_lo = d1_rem_ff;
      q_lo   = '0;
      for (int i = 0; i < NL; i++) begin
         step = div_digit({rem_lo, d1_low_ff[4*NL-1-4*i -: 4]}, d1_count_ff);
         q_lo[4*(NL-1-i) +: 4] = step[6:3];
         rem_lo = step[2:0];
      end
   end

   assign quot = {d1_qhi_ff, q_lo};

   always_comb begin
      rsp_new.smoothed   = SAMPLE_W'(quot);
      rsp_new.out_row    = d1_meta_ff.row;
      rsp_new.out_column = d1_meta_ff.col;
      rsp_new.frame_end  = d1_meta_ff.frame_end;
   end

   assign d1_valid_in = d1_ready ? in_valid : d1_valid_ff;
   assign d1_qhi_in   = d1_ready ? q_hi : d1_qhi_ff;
   assign d1_rem_in   = d1_ready ? rem_hi : d1_rem_ff;
   assign d1_low_in   = d1_ready ? sum_pad[4*NL-1:0] : d1_low_ff;
   assign d1_count_in = d1_ready ? in_count : d1_count_ff;
   assign d1_meta_in  = d1_ready ? in_meta : d1_meta_ff;
   assign d2_valid_in = d2_ready ? d1_valid_ff : d2_valid_ff;
   assign out_data_in = d2_ready ? rsp_new : out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff <= 1'b0;
         d2_valid_ff <= 1'b0;
      end else begin
         d1_valid_ff <= d1_valid_in;
         d2_valid_ff <= d2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d1_qhi_ff   <= d1_qhi_in;
      d1_rem_ff   <= d1_rem_in;
      d1_low_ff   <= d1_low_in;
      d1_count_ff <= d1_count_in;
      d1_meta_ff  <= d1_meta_in;
      out_data_ff <= out_data_in;
   end

   assign out_valid = d2_valid_ff;
   assign out_data  = out_data_ff;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cross-neighbour mean smoother.
// Streams frames of samples and drain items through the request channel,
// sets the frame size over the register port while no result is pending, predicts every
// smoothed result and checks the result channel in order, field by field.
// ----------------------------------------------------------------------------
module tb;
   import cnms_pkg::*;

   localparam int MAX_COLUMNS   = 1024;
   localparam int MAX_ROWS      = 1024;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int SETTLE_CYCLES = 8;      // pipeline is 4 deep
   localparam int REPORT_CAP    = 200;    // keep the log short on a broken build

   // -------------------------------------------------------------------------
   // Scoreboard: own copy of the frame state and the two-row line store.
   // Every accepted item is passed to it; results are matched against the queue of
   // predicted means, oldest first.
   // -------------------------------------------------------------------------
   class mean_scoreboard;
      logic [SAMPLE_W-1:0] line_rows [2*MAX_COLUMNS];
      int unsigned         in_row, in_col, drain_col;
      int unsigned         row_reg, col_reg;
      bit                  frame_full;
      cnms_rsp_type        pending_means [$];
      int unsigned         mismatches;

      function new();
         foreach (line_rows[i]) line_rows[i] = '0;
         in_row     = 0;
         in_col     = 0;
         drain_col  = 0;
         frame_full = 0;
         row_reg    = 1024;
         col_reg    = 1024;
         mismatches = 0;
      endfunction

      // 0 acts as 1, anything above the maximum acts as the maximum
      function int unsigned clamp_count(int unsigned v, int unsigned max_v);
         if (v < 1) return 1;
         if (v > max_v) return max_v;
         return v;
      endfunction

      // row r lives in half (r & 1) of the store
      function int unsigned slot(int unsigned r, int unsigned c);
         return (r & 1) * MAX_COLUMNS + (c % MAX_COLUMNS);
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
         if (idx == REG_ROW_COUNT) row_reg = val;
         else col_reg = val;
      endfunction

      function void queue_mean(int unsigned sum, int unsigned n, int unsigned r,
                               int unsigned c, bit last);
         cnms_rsp_type mean;
         mean.smoothed   = SAMPLE_W'(sum / n);
         mean.out_row    = ROW_OUT_W'(r);
         mean.out_column = COL_OUT_W'(c);
         mean.frame_end  = last;
         pending_means.push_back(mean);
      endfunction

      // one accepted item: advance the frame state, queue its result if any
      function void take_item(cnms_req_type it);
         int unsigned rows, cols, r, c, n, sum;
         rows = clamp_count(row_reg, MAX_ROWS);
         cols = clamp_count(col_reg, MAX_COLUMNS);
         if (it.op == OP_SAMPLE) begin
            if (frame_full) return;              // frame complete: sample dropped
            r = (in_row < rows) ? in_row : rows - 1;
            c = (in_col < cols) ? in_col : cols - 1;
            // the sample below completes the cross of the one above
            if (r >= 1) begin
               sum = it.sample;
               sum += line_rows[slot(r - 1, c)];
               n = 2;
               if (c > 0) begin
                  sum += line_rows[slot(r - 1, c - 1)];
                  n++;
               end
               if (c + 1 < cols) begin
                  sum += line_rows[slot(r - 1, c + 1)];
                  n++;
               end
               // two rows up shares the half of the current row
               if (r > 1) begin
                  sum += line_rows[slot(r, c)];
                  n++;
               end
               queue_mean(sum, n, r - 1, c, 1'b0);
            end
            line_rows[slot(r, c)] = it.sample;
            if (c + 1 >= cols) begin
               in_col = 0;
               if (r + 1 >= rows) begin
                  in_row     = r;
                  frame_full = 1;
                  drain_col  = 0;
               end else begin
                  in_row = r + 1;
               end
            end else begin
               in_row = r;
               in_col = c + 1;
            end
         end else begin
            if (!frame_full) return;             // nothing to drain: ignored
            r = rows - 1;
            c = (drain_col < cols) ? drain_col : cols - 1;
            sum = line_rows[slot(r, c)];
            n = 1;
            if (c > 0) begin
               sum += line_rows[slot(r, c - 1)];
               n++;
            end
            if (c + 1 < cols) begin
               sum += line_rows[slot(r, c + 1)];
               n++;
            end
            if (r > 0) begin
               sum += line_rows[slot(r - 1, c)];
               n++;
            end
            queue_mean(sum, n, r, c, c + 1 >= cols);
            if (c + 1 >= cols) begin
               frame_full = 0;
               in_row     = 0;
               in_col     = 0;
               drain_col  = 0;
            end else begin
               drain_col = c + 1;
            end
         end
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
               $display("%0t: %s mismatch, expected %0d, actual %0d",
                        $time, name, want, got);
         end
      endfunction

      function void check_result(cnms_rsp_type got);
         cnms_rsp_type want;
         if (pending_means.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
               $display("%0t: unexpected result, expected none, actual %0d row %0d col %0d",
                        $time, got.smoothed, got.out_row, got.out_column);
            return;
         end
         want = pending_means.pop_front();
         compare_field("smoothed", want.smoothed, got.smoothed);
         compare_field("out_row", want.out_row, got.out_row);
         compare_field("out_column", want.out_column, got.out_column);
         compare_field("frame_end", want.frame_end, got.frame_end);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block and its ports; every input has a known value from time zero
   // -------------------------------------------------------------------------
   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   cnms_req_type           req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   cnms_rsp_type           rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]       csr_data  = '0;

   int unsigned    send_idle = 0;    // percent of chances the sender holds off
   int unsigned    recv_idle = 0;    // percent of cycles the receiver stalls
   int unsigned    cycle_count = 0;
   int unsigned    items_sent = 0;   // items that the block acts on
   mean_scoreboard board = new();

   cross_neighbour_mean_smoother_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // receiver stalls at random; changes land on the falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // all handshakes are sampled at the rising edge, results before items so
   // that the queue order never depends on event order
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
         if (csr_valid && csr_ready) board.set_reg(csr_index, csr_data);
         if (req_valid && req_ready) board.take_item(req_data);
      end
   end

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Drivers. Each task is entered and left at a falling edge. Valid is left
   // high after an item so that a back-to-back item never lowers and raises it
   // in one step; the next call or settle() decides its value.
   // -------------------------------------------------------------------------
   task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] value);
      cnms_req_type it;
      it.op     = op;
      it.sample = value;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // frame size is only changed while nothing is in flight
   task automatic apply_frame(input int unsigned rows_val, input int unsigned cols_val);
      write_reg(REG_ROW_COUNT, CFG_W'(rows_val));
      write_reg(REG_COLUMN_COUNT, CFG_W'(cols_val));
      csr_valid <= 1'b0;
   endtask

   // wait for every predicted result, then let the pipeline run dry
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending_means.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // extremes turn up often
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return SAMPLE_W'($urandom);
   endfunction

   // One complete frame with random content. A few stray items are mixed in:
   // drains while the frame fills are ignored, samples while it drains are
   // dropped.
   task automatic random_frame(input int unsigned rows_val, input int unsigned cols_val);
      int unsigned rows, cols;
      rows = board.clamp_count(rows_val, MAX_ROWS);
      cols = board.clamp_count(cols_val, MAX_COLUMNS);
      settle();
      apply_frame(rows_val, cols_val);
      for (int i = 0; i < rows * cols; i++) begin
         if ($urandom_range(99) < 4) send_item(OP_DRAIN, SAMPLE_W'($urandom));
         send_item(OP_SAMPLE, pick_sample());
         items_sent++;
      end
      for (int i = 0; i < cols; i++) begin
         if ($urandom_range(99) < 5) send_item(OP_SAMPLE, pick_sample());
         send_item(OP_DRAIN, SAMPLE_W'($urandom));
         items_sent++;
      end
   endtask

   // mostly tiny frames, now and then a wider one; 0 sizes act as 1
   task automatic random_phase(input int unsigned budget);
      int unsigned goal;
      goal = items_sent + budget;
      while (items_sent < goal) begin
         if ($urandom_range(9) == 0)
            random_frame($urandom_range(0, 10), $urandom_range(0, 24));
         else
            random_frame($urandom_range(0, 5), $urandom_range(0, 8));
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      send_idle = 32;
      recv_idle = 85;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // drain with no full frame: ignored
      send_item(OP_DRAIN, '1);
      settle();

      // zero counts act as a 1 x 1 frame; the second sample hits a full frame
      apply_frame(0, 0);
      send_item(OP_SAMPLE, 16'hFFFF);
      send_item(OP_SAMPLE, 16'h1234);
      send_item(OP_DRAIN, '0);
      settle();

      // single row: no results until drained, divisor 2 and 3 only
      apply_frame(1, 4);
      send_item(OP_SAMPLE, 16'hFFFF);
      send_item(OP_SAMPLE, 16'hFFFF);
      send_item(OP_SAMPLE, 16'h0000);
      send_item(OP_SAMPLE, 16'hFFFF);
      repeat (4) send_item(OP_DRAIN, '0);
      settle();

      // 4 x 3 frame cut short: after row 2 column 1 the counts shrink to
      // 2 x 2, so the next position saturates and ends the frame
      apply_frame(4, 3);
      for (int i = 0; i < 8; i++) send_item(OP_SAMPLE, (i % 3 == 1) ? 16'h0000 : 16'hFFFF);
      settle();
      apply_frame(2, 2);
      send_item(OP_SAMPLE, 16'hFFFE);
      repeat (2) send_item(OP_DRAIN, '1);

      // random frames under the three idle mixes
      random_phase(200);
      send_idle = 85;
      recv_idle = 32;
      random_phase(200);
      send_idle = 0;
      recv_idle = 0;
      random_phase(200);

      // tallest frame: a row count above the maximum acts as 1024, which
      // reaches the last row
      random_frame(2047, 1);

      settle();
      if (board.mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
